FILE: hw/rtl/trace_execution_profiler_defines.svh
// assertion macros for the trace execution profiler
`ifndef TRACE_EXECUTION_PROFILER_DEFINES_SVH
`define TRACE_EXECUTION_PROFILER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TEP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("tep assertion failed");

// next-cycle implication, checked outside reset
`define TEP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("tep assertion failed");

// next-cycle implication, checked at every edge including reset
`define TEP_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("tep assertion failed");

`endif

FILE: hw/rtl/tep_pkg.sv
// shared types, constants and helpers of the trace execution profiler
package tep_pkg;

   localparam int PROG_DEPTH = 8192;
   localparam int COUNT_BITS = 32;
   localparam int ADDR_BITS  = $clog2(PROG_DEPTH);

   localparam int WORD_BITS  = 32;
   localparam int PC_BITS    = 16;
   localparam int RADDR_BITS = 13;
   localparam int RESULT_BITS = 32;
   localparam int KIND_BITS  = 8;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_ENABLE          = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CODE_INSTR      = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CODE_PC         = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CODE_SKIP       = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CODE_CYCLE      = 3'd4;

   localparam logic [KIND_BITS-1:0] RESET_CODE_INSTR = 8'd1;
   localparam logic [KIND_BITS-1:0] RESET_CODE_PC    = 8'd2;
   localparam logic [KIND_BITS-1:0] RESET_CODE_SKIP  = 8'd3;
   localparam logic [KIND_BITS-1:0] RESET_CODE_CYCLE = 8'd4;

   localparam int QUEUE_DEPTH    = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   localparam int OUT_DEPTH    = 4;
   localparam int OUT_PTR_BITS = $clog2(OUT_DEPTH);
   localparam int OUT_CNT_BITS = $clog2(OUT_DEPTH + 1);

   typedef struct packed {
      logic                  cmd;
      logic [WORD_BITS-1:0]  trace_word;
      logic [RADDR_BITS-1:0] read_address;
   } req_type;

   typedef struct packed {
      logic [RESULT_BITS-1:0] count_value;
      logic [RADDR_BITS-1:0]  count_address;
   } rsp_type;

   typedef enum logic {
      OP_BUMP,
      OP_READ
   } op_kind_type;

   typedef struct packed {
      op_kind_type           kind;
      logic [ADDR_BITS-1:0]  idx;
      logic [RADDR_BITS-1:0] read_address;
   } op_type;

   function automatic logic [ADDR_BITS-1:0] index_of(input logic [PC_BITS-1:0] addr);
      logic [PC_BITS:0] m;
      m = (PC_BITS + 1)'(addr) % (PC_BITS + 1)'(PROG_DEPTH);
      return m[ADDR_BITS-1:0];
   endfunction

endpackage

FILE: hw/rtl/tep_ram.sv
// generic single-port-write ram with registered read
module tep_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

endmodule

FILE: hw/rtl/tep_queue.sv
// short operation queue between the front and the back
module tep_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  tep_pkg::op_type push_data,
   output logic            full,
   input  logic            pop,
   output tep_pkg::op_type pop_data,
   output logic            empty
);
   import tep_pkg::*;

   op_type                    buf_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wptr_ff, wptr_in;
   logic [QUEUE_PTR_BITS-1:0] rptr_ff, rptr_in;
   logic [QUEUE_CNT_BITS-1:0] count_ff, count_in;
   logic                      do_push;
   logic                      do_pop;

   assign full     = (count_ff == QUEUE_CNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign pop_data = buf_ff[rptr_ff];
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wptr_in  = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in  = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + QUEUE_CNT_BITS'(do_push) - QUEUE_CNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         buf_ff[wptr_ff] <= push_data;
      end
   end

endmodule

FILE: hw/rtl/tep_front.sv
// front: configuration, trace word decode and program counter tracking
module tep_front (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   input  tep_pkg::req_type                       req_data,
   input  logic                                   blocked,
   input  logic                                   csr_we,
   input  logic [tep_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  logic [tep_pkg::CSR_DATA_BITS-1:0]      csr_wdata,
   output logic                                   op_push,
   output tep_pkg::op_type                        op_data
);
   import tep_pkg::*;

   logic                 enable_ff;
   logic [KIND_BITS-1:0] code_instr_ff;
   logic [KIND_BITS-1:0] code_pc_ff;
   logic [KIND_BITS-1:0] code_skip_ff;
   logic [KIND_BITS-1:0] code_cycle_ff;
   logic [PC_BITS-1:0]   running_pc_ff, running_pc_in;
   logic [PC_BITS-1:0]   instr_addr_ff, instr_addr_in;

   logic                 accept;
   logic                 trace_on;
   logic [KIND_BITS-1:0] kind;
   logic                 is_instr;
   logic                 is_pc;
   logic                 is_cycle;

   assign accept   = req_push && !blocked;
   assign kind     = req_data.trace_word[WORD_BITS-1 -: KIND_BITS];
   assign trace_on = accept && !req_data.cmd && enable_ff;
   assign is_instr = (kind == code_instr_ff);
   assign is_pc    = !is_instr && (kind == code_pc_ff || kind == code_skip_ff);
   assign is_cycle = !is_instr && !is_pc && (kind == code_cycle_ff);

   always_comb begin
      running_pc_in = running_pc_ff;
      instr_addr_in = instr_addr_ff;
      op_push       = 1'b0;
      op_data.kind  = OP_BUMP;
      op_data.idx   = index_of(instr_addr_ff);
      op_data.read_address = req_data.read_address;
      if (accept && req_data.cmd) begin
         op_push      = 1'b1;
         op_data.kind = OP_READ;
         op_data.idx  = index_of(PC_BITS'(req_data.read_address));
      end else if (trace_on) begin
         if (is_instr) begin
            op_push       = 1'b1;
            op_data.idx   = index_of(running_pc_ff);
            instr_addr_in = running_pc_ff;
            running_pc_in = running_pc_ff + 1'b1;
         end else if (is_pc) begin
            running_pc_in = req_data.trace_word[PC_BITS-1:0];
         end else if (is_cycle) begin
            op_push = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff     <= 1'b0;
         code_instr_ff <= RESET_CODE_INSTR;
         code_pc_ff    <= RESET_CODE_PC;
         code_skip_ff  <= RESET_CODE_SKIP;
         code_cycle_ff <= RESET_CODE_CYCLE;
         running_pc_ff <= '0;
         instr_addr_ff <= '0;
      end else begin
         running_pc_ff <= running_pc_in;
         instr_addr_ff <= instr_addr_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ENABLE:     enable_ff     <= csr_wdata[0];
               CSR_CODE_INSTR: code_instr_ff <= csr_wdata;
               CSR_CODE_PC:    code_pc_ff    <= csr_wdata;
               CSR_CODE_SKIP:  code_skip_ff  <= csr_wdata;
               CSR_CODE_CYCLE: code_cycle_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

endmodule

FILE: hw/rtl/tep_back.sv
// back: counter store read-modify-write, clearing pass and response buffer
module tep_back (
   input  logic             clock,
   input  logic             reset,
   input  tep_pkg::op_type  q_head,
   input  logic             q_empty,
   output logic             q_pop,
   output logic             clearing,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output tep_pkg::rsp_type rsp_data
);
   import tep_pkg::*;

   logic                    clearing_ff, clearing_in;
   logic [ADDR_BITS-1:0]    clr_ff, clr_in;
   logic                    s1_valid_ff;
   op_type                  s1_op_ff;
   logic                    wr_valid_ff;
   logic [ADDR_BITS-1:0]    wr_idx_ff;
   logic [COUNT_BITS-1:0]   wr_data_ff;

   rsp_type                 out_buf_ff [OUT_DEPTH];
   logic [OUT_PTR_BITS-1:0] out_wptr_ff, out_wptr_in;
   logic [OUT_PTR_BITS-1:0] out_rptr_ff, out_rptr_in;
   logic [OUT_CNT_BITS-1:0] out_count_ff, out_count_in;

   logic [COUNT_BITS-1:0]   ram_rdata;
   logic                    ram_we;
   logic [ADDR_BITS-1:0]    ram_waddr;
   logic [COUNT_BITS-1:0]   ram_wdata;
   logic [COUNT_BITS-1:0]   cur;
   logic [COUNT_BITS-1:0]   bumped;
   logic [63:0]             cur_wide;
   logic                    s1_read;
   logic                    s1_bump;
   logic                    out_push;
   logic                    out_pop;
   rsp_type                 result;

   tep_ram #(
      .WIDTH(COUNT_BITS),
      .DEPTH(PROG_DEPTH)
   ) u_counts (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_en  (q_pop),
      .rd_addr(q_head.idx),
      .rd_data(ram_rdata)
   );

   assign clearing  = clearing_ff;
   assign rsp_empty = (out_count_ff == '0);
   assign rsp_data  = out_buf_ff[out_rptr_ff];
   assign s1_read   = s1_valid_ff && (s1_op_ff.kind == OP_READ);
   assign s1_bump   = s1_valid_ff && (s1_op_ff.kind == OP_BUMP);
   assign out_push  = s1_read;
   assign out_pop   = rsp_pop && !rsp_empty;

   always_comb begin
      q_pop = !q_empty && !clearing_ff &&
              (q_head.kind != OP_READ ||
               (out_count_ff + OUT_CNT_BITS'(s1_read)) < OUT_CNT_BITS'(OUT_DEPTH));

      // forward the write of the previous cycle
      cur      = (wr_valid_ff && wr_idx_ff == s1_op_ff.idx) ? wr_data_ff : ram_rdata;
      bumped   = (&cur) ? cur : cur + 1'b1;
      cur_wide = 64'(cur);

      result.count_value   = (cur_wide > 64'(32'hffff_ffff)) ? '1 : cur_wide[RESULT_BITS-1:0];
      result.count_address = s1_op_ff.read_address;

      if (clearing_ff) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
         ram_wdata = '0;
      end else begin
         ram_we    = s1_bump;
         ram_waddr = s1_op_ff.idx;
         ram_wdata = bumped;
      end

      clr_in      = clr_ff + 1'b1;
      clearing_in = clearing_ff && (clr_ff != ADDR_BITS'(PROG_DEPTH - 1));

      out_wptr_in  = out_push ? out_wptr_ff + 1'b1 : out_wptr_ff;
      out_rptr_in  = out_pop ? out_rptr_ff + 1'b1 : out_rptr_ff;
      out_count_in = out_count_ff + OUT_CNT_BITS'(out_push) - OUT_CNT_BITS'(out_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff  <= 1'b1;
         clr_ff       <= '0;
         s1_valid_ff  <= 1'b0;
         wr_valid_ff  <= 1'b0;
         out_wptr_ff  <= '0;
         out_rptr_ff  <= '0;
         out_count_ff <= '0;
      end else begin
         clearing_ff  <= clearing_in;
         clr_ff       <= clearing_ff ? clr_in : clr_ff;
         s1_valid_ff  <= q_pop;
         wr_valid_ff  <= s1_bump;
         out_wptr_ff  <= out_wptr_in;
         out_rptr_ff  <= out_rptr_in;
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s1_op_ff <= q_head;
      end
      wr_idx_ff  <= s1_op_ff.idx;
      wr_data_ff <= bumped;
      if (out_push) begin
         out_buf_ff[out_wptr_ff] <= result;
      end
   end

endmodule

FILE: hw/rtl/trace_execution_profiler.sv
// top level of the trace execution profiler
//
// channel   direction  handshake            payload
// req       in         req_push / req_full  req_data  (cmd, trace_word, read_address)
// rsp       out        rsp_pop / rsp_empty  rsp_data  (count_value, count_address)
// csr       in         csr_we               csr_index, csr_wdata
//
// one request per cycle while not req_full; reads pass op queue, s1 and rsp buffer
// instruction and cycle words each cost one pipelined counter read-modify-write
// after reset a clearing pass zeroes all 8192 store entries, req_full is high
// req_full also rises when the 4-entry op queue fills behind a stalled rsp side
module trace_execution_profiler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_push,
   output logic                               req_full,
   input  tep_pkg::req_type                   req_data,
   output logic                               rsp_empty,
   input  logic                               rsp_pop,
   output tep_pkg::rsp_type                   rsp_data,
   input  logic                               csr_we,
   input  logic [tep_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [tep_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);
   import tep_pkg::*;

   logic   op_push;
   op_type op_data;
   logic   q_full;
   logic   q_pop;
   logic   q_empty;
   op_type q_head;
   logic   clearing;

   assign req_full = q_full || clearing;

   tep_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .blocked  (req_full),
      .csr_we   (csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .op_push  (op_push),
      .op_data  (op_data)
   );

   tep_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (op_push),
      .push_data(op_data),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_head),
      .empty    (q_empty)
   );

   tep_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_head   (q_head),
      .q_empty  (q_empty),
      .q_pop    (q_pop),
      .clearing (clearing),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data)
   );

endmodule

FILE: hw/rtl/tep_checker.sv
// port-level assertions of the trace execution profiler and their bind
`include "trace_execution_profiler_defines.svh"

module tep_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_push,
   input logic                               req_full,
   input tep_pkg::req_type                   req_data,
   input logic                               rsp_empty,
   input logic                               rsp_pop,
   input tep_pkg::rsp_type                   rsp_data,
   input logic                               csr_we,
   input logic [tep_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input logic [tep_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   // clearing pass blocks requests right after reset
   `TEP_ASSERT_ALWAYS_NEXT(full_after_reset, clock, reset, req_full)
   `TEP_ASSERT_ALWAYS_NEXT(empty_after_reset, clock, reset, rsp_empty)
   // a waiting response holds until taken
   `TEP_ASSERT_NEXT(rsp_holds, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_data))
   // nothing accepted while full, with or without csr traffic, never raises a response from empty
   `TEP_ASSERT_NEXT(no_rsp_from_nothing, clock, reset, rsp_empty && req_full && $past(req_full) && $past(req_full, 2) && $past(req_full, 3) && $past(rsp_empty, 3) && $past(rsp_empty, 2) && $past(rsp_empty), rsp_empty)

endmodule

bind trace_execution_profiler tep_checker u_checker (.*);
